// ===== hdl/hta_pkg.sv =====
// Shared types, constants and control store for the handle table allocator.
// No dependencies; imported by handle_table_allocator.
package hta_pkg;

	localparam int MAX_SLOTS  = 256;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CAP_W      = 9;
	localparam int HOUT_W     = 8;
	localparam int FIRST_FREE = 3;
	localparam int MIN_CAP    = 4;

	localparam int OPS_W  = 64;
	localparam int CTX_W  = 64;
	localparam int FLG_W  = 32;
	localparam int HDL_W  = 32;
	localparam int ENTRY_W = OPS_W + CTX_W + FLG_W;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_ALLOC   = 3'd0;
	localparam cmd_t CMD_INSTALL = 3'd1;
	localparam cmd_t CMD_LOOKUP  = 3'd2;
	localparam cmd_t CMD_RELEASE = 3'd3;
	localparam cmd_t CMD_QUERY   = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_INVALID  = 3'd1;
	localparam status_t ST_EMPTY    = 3'd2;
	localparam status_t ST_RESERVED = 3'd3;
	localparam status_t ST_FULL     = 3'd4;

	// step counter addresses of the control program
	typedef logic [3:0] upc_t;
	localparam upc_t U_WAIT    = 4'd0;
	localparam upc_t U_DECODE  = 4'd1;
	localparam upc_t U_SCAN    = 4'd2;
	localparam upc_t U_ALLOC   = 4'd3;
	localparam upc_t U_INSTALL = 4'd4;
	localparam upc_t U_READ    = 4'd5;
	localparam upc_t U_LATCH   = 4'd6;
	localparam upc_t U_RELEASE = 4'd7;
	localparam upc_t U_RESULT  = 4'd8;

	typedef enum logic [3:0] {
		A_NOP,
		A_ACCEPT,
		A_DECODE,
		A_SCAN,
		A_WRITE,
		A_READ,
		A_LATCH,
		A_RELEASE,
		A_LOAD_OUT
	} act_t;

	typedef enum logic [2:0] {
		BR_GOTO,
		BR_ACCEPT,
		BR_DISPATCH,
		BR_SCAN,
		BR_HOLD_OUT
	} br_t;

	typedef struct packed {
		act_t act;
		br_t  br;
		upc_t target;
	} uword_t;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		case (pc)
			U_WAIT:    w = '{act: A_ACCEPT,   br: BR_ACCEPT,   target: U_DECODE};
			U_DECODE:  w = '{act: A_DECODE,   br: BR_DISPATCH, target: U_RESULT};
			U_SCAN:    w = '{act: A_SCAN,     br: BR_SCAN,     target: U_RESULT};
			U_ALLOC:   w = '{act: A_WRITE,    br: BR_GOTO,     target: U_RESULT};
			U_INSTALL: w = '{act: A_WRITE,    br: BR_GOTO,     target: U_RESULT};
			U_READ:    w = '{act: A_READ,     br: BR_GOTO,     target: U_LATCH};
			U_LATCH:   w = '{act: A_LATCH,    br: BR_GOTO,     target: U_RESULT};
			U_RELEASE: w = '{act: A_RELEASE,  br: BR_GOTO,     target: U_RESULT};
			U_RESULT:  w = '{act: A_LOAD_OUT, br: BR_HOLD_OUT, target: U_WAIT};
			default:   w = '{act: A_NOP,      br: BR_GOTO,     target: U_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/hta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/handle_table_allocator.sv =====
// Handle table allocator, microcoded: one item at a time, program in hta_pkg::ucode.
// Per request: accept, decode, then result directly if refused; install writes, release
// clears the used bit, lookup and flags query read then latch, and alloc scans one slot
// per cycle until it writes a free slot or has tested capacity slots on a full table.
// A new item can be taken in the cycle after the result is registered.
// Reset: all slots empty at once (per-slot used bits), capacity 256, next pointer 3.
module handle_table_allocator
	import hta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    capacity,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          command,
	input  logic signed [HDL_W-1:0] handle,
	input  logic [OPS_W-1:0]    ops_word,
	input  logic [CTX_W-1:0]    context_word,
	input  logic [FLG_W-1:0]    flags_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [HOUT_W-1:0]   handle_out,
	output logic [OPS_W-1:0]    ops_word_out,
	output logic [CTX_W-1:0]    context_word_out,
	output logic [FLG_W-1:0]    flags_out
);

	uword_t uw;
	upc_t   upc_q;
	upc_t   upc_nx;
	upc_t   dispatch_pc;

	logic [CAP_W-1:0]     cap_q;
	logic [CAP_W-1:0]     np_q;
	logic [CAP_W-1:0]     np_inc;
	logic [CAP_W-1:0]     np_nx;
	logic [CAP_W-1:0]     cnt_q;
	logic [CAP_W-1:0]     cnt_inc;
	logic [MAX_SLOTS-1:0] used_q;
	logic [SLOT_W-1:0]    idx_q;

	cmd_t              cmd_q;
	logic [HDL_W-1:0]  handle_q;
	logic [OPS_W-1:0]  ops_q;
	logic [CTX_W-1:0]  ctx_q;
	logic [FLG_W-1:0]  flags_q;

	status_t           r_status_q;
	logic [HOUT_W-1:0] r_handle_q;
	logic [OPS_W-1:0]  r_ops_q;
	logic [CTX_W-1:0]  r_ctx_q;
	logic [FLG_W-1:0]  r_flags_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [HOUT_W-1:0] handle_out_q;
	logic [OPS_W-1:0]  ops_out_q;
	logic [CTX_W-1:0]  ctx_out_q;
	logic [FLG_W-1:0]  flags_out_q;

	logic               accept;
	logic               cfg_wr;
	logic               h_valid;
	logic [SLOT_W-1:0]  h_slot;
	status_t            d_status;
	logic               hit;
	logic               done;
	logic               out_free;
	logic               load_out;
	logic               ram_we;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [CAP_W-1:0]   cap_clamped;

	assign uw        = ucode(upc_q);
	assign in_ready  = (uw.act == A_ACCEPT);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign cap_clamped = (capacity < CAP_W'(MIN_CAP))   ? CAP_W'(MIN_CAP) :
	                     (capacity > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : capacity;

	// handle check: non-negative and below capacity
	assign h_slot  = handle_q[SLOT_W-1:0];
	assign h_valid = !handle_q[HDL_W-1] && (handle_q[HDL_W-2:CAP_W] == '0) &&
	                 (handle_q[CAP_W-1:0] < cap_q);

	always_comb begin
		d_status = ST_OK;
		case (cmd_q)
			CMD_ALLOC: begin
				d_status = ST_FULL;
			end
			CMD_INSTALL: begin
				if (!h_valid) begin
					d_status = ST_INVALID;
				end
			end
			CMD_LOOKUP, CMD_QUERY: begin
				if (!h_valid) begin
					d_status = ST_INVALID;
				end else if (!used_q[h_slot]) begin
					d_status = ST_EMPTY;
				end
			end
			CMD_RELEASE: begin
				if (!h_valid) begin
					d_status = ST_INVALID;
				end else if (!used_q[h_slot]) begin
					d_status = ST_EMPTY;
				end else if (h_slot < SLOT_W'(FIRST_FREE)) begin
					d_status = ST_RESERVED;
				end
			end
			default: begin
				d_status = ST_INVALID;
			end
		endcase
	end

	always_comb begin
		dispatch_pc = uw.target;
		case (cmd_q)
			CMD_ALLOC: dispatch_pc = U_SCAN;
			CMD_INSTALL: begin
				if (d_status == ST_OK) begin
					dispatch_pc = U_INSTALL;
				end
			end
			CMD_LOOKUP, CMD_QUERY: begin
				if (d_status == ST_OK) begin
					dispatch_pc = U_READ;
				end
			end
			CMD_RELEASE: begin
				if (d_status == ST_OK) begin
					dispatch_pc = U_RELEASE;
				end
			end
			default: dispatch_pc = uw.target;
		endcase
	end

	// round-robin scan, one slot per cycle
	assign np_inc  = np_q + 1'b1;
	assign np_nx   = (np_inc >= cap_q) ? CAP_W'(FIRST_FREE) : np_inc;
	assign hit     = (np_q < cap_q) && !used_q[np_q[SLOT_W-1:0]];
	assign cnt_inc = cnt_q + 1'b1;
	assign done    = (cnt_inc == cap_q);

	assign out_free = !out_valid_q || out_ready;
	assign load_out = (uw.act == A_LOAD_OUT) && out_free;

	always_comb begin
		case (uw.br)
			BR_GOTO:     upc_nx = uw.target;
			BR_ACCEPT:   upc_nx = accept ? uw.target : upc_q;
			BR_DISPATCH: upc_nx = dispatch_pc;
			BR_SCAN:     upc_nx = hit ? upc_t'(upc_q + 1'b1) : (done ? uw.target : upc_q);
			BR_HOLD_OUT: upc_nx = out_free ? uw.target : upc_q;
			default:     upc_nx = U_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_WAIT;
			cap_q       <= CAP_W'(MAX_SLOTS);
			np_q        <= CAP_W'(FIRST_FREE);
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_nx;
			if (cfg_wr) begin
				cap_q <= cap_clamped;
				np_q  <= CAP_W'(FIRST_FREE);
			end else if (uw.act == A_SCAN) begin
				np_q <= np_nx;
			end
			if (uw.act == A_WRITE) begin
				used_q[idx_q] <= |ops_q;
			end else if (uw.act == A_RELEASE) begin
				used_q[idx_q] <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(command);
			handle_q <= handle;
			ops_q    <= ops_word;
			ctx_q    <= context_word;
			flags_q  <= flags_in;
		end
		case (uw.act)
			A_DECODE: begin
				r_status_q <= d_status;
				r_handle_q <= '0;
				r_ops_q    <= '0;
				r_ctx_q    <= '0;
				r_flags_q  <= '0;
				cnt_q      <= '0;
				idx_q      <= h_slot;
			end
			A_SCAN: begin
				cnt_q <= cnt_inc;
				if (hit) begin
					idx_q      <= np_q[SLOT_W-1:0];
					r_status_q <= ST_OK;
					r_handle_q <= np_q[HOUT_W-1:0];
				end
			end
			A_LATCH: begin
				r_flags_q <= ram_rdata[FLG_W-1:0];
				if (cmd_q == CMD_LOOKUP) begin
					r_ops_q <= ram_rdata[ENTRY_W-1 -: OPS_W];
					r_ctx_q <= ram_rdata[FLG_W +: CTX_W];
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			status_q     <= r_status_q;
			handle_out_q <= r_handle_q;
			ops_out_q    <= r_ops_q;
			ctx_out_q    <= r_ctx_q;
			flags_out_q  <= r_flags_q;
		end
	end

	assign ram_we = (uw.act == A_WRITE);
	assign ram_re = (uw.act == A_READ);

	hta_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata({ops_q, ctx_q, flags_q}),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign handle_out       = handle_out_q;
	assign ops_word_out     = ops_out_q;
	assign context_word_out = ctx_out_q;
	assign flags_out        = flags_out_q;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(np_q >= CAP_W'(FIRST_FREE)) && (np_q < cap_q))
		else $error("next pointer outside 3..capacity-1");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q >= CAP_W'(MIN_CAP)) && (cap_q <= CAP_W'(MAX_SLOTS)))
		else $error("capacity outside 4..MAX_SLOTS");

	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_ALLOC) |-> !used_q[idx_q])
		else $error("alloc writes a used slot");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_FULL)) |->
		((handle_out_q == '0) && (ops_out_q == '0) && (flags_out_q == '0)))
		else $error("full table result carries data");

endmodule

// ===== tb/sv/handle_table_checker.sv =====
// Checker for the handle table allocator: watches config, request and reply beats,
// keeps its own copy of the slot table and compares every reply field by field.
// Depends on hta_pkg for widths, commands and status codes.
module handle_table_checker
	import hta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CAP_W-1:0]  capacity,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [2:0]        command,
	input  logic [HDL_W-1:0]  handle,
	input  logic [OPS_W-1:0]  ops_word,
	input  logic [CTX_W-1:0]  context_word,
	input  logic [FLG_W-1:0]  flags_in,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic [HOUT_W-1:0] handle_out,
	input  logic [OPS_W-1:0]  ops_word_out,
	input  logic [CTX_W-1:0]  context_word_out,
	input  logic [FLG_W-1:0]  flags_out,
	output int                errors,
	output int                outstanding,
	output int                replies
);

	typedef struct packed {
		status_t             st;
		logic [HOUT_W-1:0]   hdl;
		logic [OPS_W-1:0]    ops;
		logic [CTX_W-1:0]    ctx;
		logic [FLG_W-1:0]    flg;
	} reply_t;

	reply_t            pending_replies[$];
	reply_t            want;
	logic [OPS_W-1:0]  ops_tbl [MAX_SLOTS];
	logic [CTX_W-1:0]  ctx_tbl [MAX_SLOTS];
	logic [FLG_W-1:0]  flg_tbl [MAX_SLOTS];
	logic [CAP_W-1:0]  cap_reg;
	int unsigned       next_slot;
	int                err_cnt;
	int                reply_cnt;
	int                k;

	function automatic int unsigned slots_in_use(input logic [CAP_W-1:0] c);
		if (c < MIN_CAP)
			return MIN_CAP;
		if (c > MAX_SLOTS)
			return MAX_SLOTS;
		return 32'(c);
	endfunction

	task automatic write_slot(input int unsigned s, input logic [OPS_W-1:0] o,
			input logic [CTX_W-1:0] c, input logic [FLG_W-1:0] f);
		ops_tbl[s] = o;
		ctx_tbl[s] = c;
		flg_tbl[s] = f;
	endtask

	// Predicts the reply and advances the table and next pointer as the block does for one request.
	task automatic predict_reply(input logic [2:0] cmd, input logic [HDL_W-1:0] hdl,
			input logic [OPS_W-1:0] o, input logic [CTX_W-1:0] c,
			input logic [FLG_W-1:0] f, output reply_t r);
		int unsigned cap;
		int unsigned n;
		int unsigned s;
		bit          ok;
		bit          found;
		r     = '0;
		cap   = slots_in_use(cap_reg);
		ok    = !hdl[HDL_W-1] && (hdl < cap);
		s     = 32'(hdl[SLOT_W-1:0]);
		found = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				r.st = ST_FULL;
				n = 0;
				while (!found && n < cap) begin
					s = next_slot;
					next_slot++;
					if (next_slot >= cap)
						next_slot = FIRST_FREE;
					if (s < cap && ops_tbl[s] == '0) begin
						write_slot(s, o, c, f);
						r.st  = ST_OK;
						r.hdl = s[HOUT_W-1:0];
						found = 1'b1;
					end
					n++;
				end
			end
			CMD_INSTALL: begin
				if (!ok)
					r.st = ST_INVALID;
				else
					write_slot(s, o, c, f);
			end
			CMD_LOOKUP: begin
				if (!ok)
					r.st = ST_INVALID;
				else if (ops_tbl[s] == '0)
					r.st = ST_EMPTY;
				else begin
					r.ops = ops_tbl[s];
					r.ctx = ctx_tbl[s];
					r.flg = flg_tbl[s];
				end
			end
			CMD_RELEASE: begin
				if (!ok)
					r.st = ST_INVALID;
				else if (ops_tbl[s] == '0)
					r.st = ST_EMPTY;
				else if (s < FIRST_FREE)
					r.st = ST_RESERVED;
				else
					write_slot(s, '0, '0, '0);
			end
			CMD_QUERY: begin
				if (!ok)
					r.st = ST_INVALID;
				else if (ops_tbl[s] == '0)
					r.st = ST_EMPTY;
				else
					r.flg = flg_tbl[s];
			end
			default: r.st = ST_INVALID;
		endcase
	endtask

	task automatic report_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < MAX_SLOTS; k++)
				write_slot(k, '0, '0, '0);
			cap_reg   = CAP_W'(MAX_SLOTS);
			next_slot = FIRST_FREE;
			pending_replies.delete();
			err_cnt   = 0;
			reply_cnt = 0;
			errors      <= 0;
			outstanding <= 0;
			replies     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_reg   = capacity;
				next_slot = FIRST_FREE;
			end
			if (in_valid && in_ready) begin
				predict_reply(command, handle, ops_word, context_word, flags_in, want);
				pending_replies.push_back(want);
			end
			if (out_valid && out_ready) begin
				reply_cnt++;
				if (pending_replies.size() == 0) begin
					$error("reply beat with no request outstanding");
					err_cnt++;
				end else begin
					want = pending_replies.pop_front();
					report_field("status", 64'(want.st), 64'(status));
					report_field("handle_out", 64'(want.hdl), 64'(handle_out));
					report_field("ops_word_out", want.ops, ops_word_out);
					report_field("context_word_out", want.ctx, context_word_out);
					report_field("flags_out", 64'(want.flg), 64'(flags_out));
				end
			end
			errors      <= err_cnt;
			outstanding <= pending_replies.size();
			replies     <= reply_cnt;
		end
	end

endmodule

// ===== tb/sv/handle_table_allocator_test.sv =====
// Top of the handle table allocator testbench: clock, reset, directed and random
// request beats, capacity writes, reply back-pressure, watchdog and verdict.
// Depends on hta_pkg, handle_table_allocator and handle_table_checker.
module handle_table_allocator_test;
	import hta_pkg::*;

	localparam int DRAIN_CYCLES   = 270;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 66;
	localparam int N_PHASES       = 8;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CAP_W-1:0]        capacity     = '0;
	logic                    in_valid     = 1'b0;
	logic                    in_ready;
	logic [2:0]              command      = CMD_ALLOC;
	logic signed [HDL_W-1:0] handle       = '0;
	logic [OPS_W-1:0]        ops_word     = '0;
	logic [CTX_W-1:0]        context_word = '0;
	logic [FLG_W-1:0]        flags_in     = '0;
	logic                    out_valid;
	logic                    out_ready    = 1'b0;
	logic [2:0]              status;
	logic [HOUT_W-1:0]       handle_out;
	logic [OPS_W-1:0]        ops_word_out;
	logic [CTX_W-1:0]        context_word_out;
	logic [FLG_W-1:0]        flags_out;

	int          errors;
	int          outstanding;
	int          replies;
	int          idle_cycles  = 0;
	int          n_sent       = 0;
	int          n_cfg        = 0;
	int unsigned cap_now      = MAX_SLOTS;
	bit          quiet        = 1'b0;
	int          phase_caps[N_PHASES] = '{511, 5, 16, 258, 3, 7, 256, 9};
	int          p;
	int          i;

	handle_table_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .handle(handle),
		.ops_word(ops_word), .context_word(context_word), .flags_in(flags_in),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.handle_out(handle_out), .ops_word_out(ops_word_out),
		.context_word_out(context_word_out), .flags_out(flags_out)
	);

	handle_table_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity(capacity),
		.in_valid(in_valid), .in_ready(in_ready), .command(command), .handle(handle),
		.ops_word(ops_word), .context_word(context_word), .flags_in(flags_in),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.handle_out(handle_out), .ops_word_out(ops_word_out),
		.context_word_out(context_word_out), .flags_out(flags_out),
		.errors(errors), .outstanding(outstanding), .replies(replies)
	);

	always #6 clk = ~clk;

	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(99) >= 6);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic [2:0] cmd, input logic [HDL_W-1:0] hdl,
			input logic [OPS_W-1:0] o, input logic [CTX_W-1:0] c,
			input logic [FLG_W-1:0] f);
		if (!quiet) begin
			while ($urandom_range(99) < 6) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		handle       <= hdl;
		ops_word     <= o;
		context_word <= c;
		flags_in     <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	// sender holds off until every reply has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		capacity  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cap_now = (v < MIN_CAP) ? MIN_CAP : ((v > MAX_SLOTS) ? MAX_SLOTS : v);
		n_cfg++;
	endtask

	task automatic random_request();
		int unsigned       pick;
		logic [2:0]        cmd;
		logic [HDL_W-1:0]  hdl;
		logic [OPS_W-1:0]  o;
		pick = $urandom_range(99);
		if (pick < 30)
			cmd = CMD_ALLOC;
		else if (pick < 38)
			cmd = CMD_INSTALL;
		else if (pick < 60)
			cmd = CMD_LOOKUP;
		else if (pick < 82)
			cmd = CMD_RELEASE;
		else if (pick < 96)
			cmd = CMD_QUERY;
		else
			cmd = CMD_QUERY + 3'($urandom_range(1, 3));
		pick = $urandom_range(99);
		if (pick < 75)
			hdl = $urandom_range(cap_now - 1);
		else if (pick < 85)
			hdl = cap_now + $urandom_range(3);
		else
			hdl = $urandom;
		o = ($urandom_range(99) < 10) ? '0 : {$urandom, $urandom};
		send_request(cmd, hdl, o, {$urandom, $urandom}, $urandom);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset capacity
		send_request(CMD_LOOKUP, 5, '0, '0, '0);
		send_request(CMD_QUERY, 5, '0, '0, '0);
		send_request(CMD_RELEASE, 1, '0, '0, '0);
		send_request(CMD_ALLOC, 0, '0, '0, '0);
		send_request(CMD_LOOKUP, 3, '0, '0, '0);
		send_request(CMD_ALLOC, '1, '1, '1, '1);
		send_request(CMD_LOOKUP, 4, '0, '0, '0);
		send_request(CMD_QUERY, 4, '0, '0, '0);
		send_request(CMD_RELEASE, 4, '0, '0, '0);
		send_request(CMD_LOOKUP, 4, '0, '0, '0);
		send_request(CMD_INSTALL, 0, '1, '1, '1);
		send_request(CMD_LOOKUP, 0, '0, '0, '0);
		send_request(CMD_RELEASE, 0, '0, '0, '0);
		send_request(CMD_INSTALL, 255, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
			32'h5a5a_a5a5);
		send_request(CMD_QUERY, 255, '0, '0, '0);
		send_request(CMD_INSTALL, 256, '1, '1, '1);
		send_request(CMD_INSTALL, 32'hffff_ffff, '1, '1, '1);
		send_request(CMD_LOOKUP, 32'h7fff_ffff, '0, '0, '0);
		send_request(CMD_RELEASE, 32'h8000_0000, '0, '0, '0);
		send_request(CMD_QUERY + 3'd1, 3, '1, '1, '1);
		send_request(CMD_QUERY + 3'd2, 0, '1, '1, '1);
		send_request(CMD_QUERY + 3'd3, '1, '1, '1, '1);
		send_request(CMD_INSTALL, 2, 64'd1, '0, 32'd7);
		send_request(CMD_RELEASE, 2, '0, '0, '0);

		// capacity below minimum clamps to four slots: one free, then full
		write_capacity('0);
		send_request(CMD_ALLOC, 0, 64'd9, 64'd8, 32'd7);
		send_request(CMD_ALLOC, 0, 64'd6, 64'd5, 32'd4);
		send_request(CMD_LOOKUP, 3, '0, '0, '0);
		send_request(CMD_LOOKUP, 4, '0, '0, '0);

		phase_caps[5] = $urandom_range(6, 48);
		for (p = 0; p < N_PHASES; p++) begin
			write_capacity(CAP_W'(phase_caps[p]));
			quiet = (p == 2);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) == 0)
					wait_drained();
				random_request();
			end
		end
		quiet = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests, directed and random, across %0d capacity writes",
			n_sent, n_cfg);
		$display("including clamped extremes; %0d reply beats checked.", replies);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/hta_pkg.sv
hdl/hta_ram.sv
hdl/handle_table_allocator.sv
tb/sv/handle_table_checker.sv
tb/sv/handle_table_allocator_test.sv
